FILE: rtl/core/minv_pkg.sv
// Package with shared constants, types and helpers of the 4x4 matrix inverse.
`timescale 1ns / 1ps
package minv_pkg;

  localparam int MINV_ELEMENT_WIDTH = 32;
  localparam int MINV_FRAC_BITS = 16;
  // Slice width of the wide operand in the shared multiplier.
  localparam int MINV_CHUNK = 16;

  typedef enum logic [1:0] {
    YS_ELEM  = 2'd0,
    YS_MINOR = 2'd1,
    YS_COF   = 2'd2
  } minv_ysrc_t;

  typedef struct packed {
    logic       wr_en;
    logic [1:0] wr_row;
    logic [1:0] mat_row;
    logic [3:0] cof_addr;
    logic       ld_y;
    minv_ysrc_t ysrc;
    logic [1:0] ycol;
    logic [1:0] ymin;
    logic       ld_x;
    logic [1:0] xcol;
    logic       acc_en;
    logic       acc_clr;
    logic       acc_sub;
    logic       st_minor;
    logic [1:0] st_idx;
    logic       st_cof;
    logic       st_det;
    logic       dmag_en;
    logic       div_load;
    logic       div_pre;
    logic       div_chk;
    logic       div_step;
    logic       div_fin;
    logic [1:0] div_col;
    logic       emit;
  } minv_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_last;
  } minv_status_t;

  // Index n of the three values in 0..3 that remain when s is removed.
  function automatic logic [1:0] minv_skip(input logic [1:0] n, input logic [1:0] s);
    return n + {1'b0, (n >= s)};
  endfunction

endpackage

FILE: rtl/core/minv_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module minv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/minv_ctrl.sv
// Sequencer that walks the cofactor, determinant and division steps.
`timescale 1ns / 1ps
module minv_ctrl import minv_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  minv_status_t status,
  output minv_cmd_t    cmd,
  output logic         busy,
  output logic         valid,
  output logic         last_row
);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_RDY   = 15'b000000000000010,
    S_LDY   = 15'b000000000000100,
    S_LDX   = 15'b000000000001000,
    S_MUL   = 15'b000000000010000,
    S_ACC   = 15'b000000000100000,
    S_STORE = 15'b000000001000000,
    S_DMAG  = 15'b000000010000000,
    S_DRD   = 15'b000000100000000,
    S_DLD   = 15'b000001000000000,
    S_DPRE  = 15'b000010000000000,
    S_DCHK  = 15'b000100000000000,
    S_DIT   = 15'b001000000000000,
    S_DFIN  = 15'b010000000000000,
    S_EMIT  = 15'b100000000000000
  } state_t;

  typedef enum logic [3:0] {
    PH_MINOR = 4'b0001,
    PH_SUM   = 4'b0010,
    PH_DET   = 4'b0100,
    PH_DIV   = 4'b1000
  } phase_t;

  state_t     state, state_next;
  phase_t     phase, phase_next;
  logic [1:0] r, r_next, c, c_next, m, m_next, k, k_next, rc, rc_next;

  logic [1:0] rr0, rr1, rr2, kk0, kk1, kk2, pc, qc, kc;
  logic [1:0] xrow, xcol, yrow, ycol;
  logic [3:0] op_cof;
  minv_ysrc_t ysrc;
  logic       op_sub, op_last;

  always_comb begin
    rr0 = minv_skip(2'd0, r);
    rr1 = minv_skip(2'd1, r);
    rr2 = minv_skip(2'd2, r);
    kk0 = minv_skip(2'd0, c);
    kk1 = minv_skip(2'd1, c);
    kk2 = minv_skip(2'd2, c);
    kc  = minv_skip(k, c);
    pc  = (m == 2'd0) ? kk1 : kk0;
    qc  = (m == 2'd2) ? kk1 : kk2;
    xrow = rr1;
    xcol = (k == 2'd0) ? pc : qc;
    yrow = rr2;
    ycol = (k == 2'd0) ? qc : pc;
    ysrc = YS_ELEM;
    op_sub = (k == 2'd1);
    op_last = (k == 2'd1);
    op_cof = {c, r};
    case (phase)
      PH_MINOR: begin
      end
      PH_SUM: begin
        xrow = rr0;
        xcol = kc;
        ysrc = YS_MINOR;
        op_sub = (k == 2'd1) ^ r[0] ^ c[0];
        op_last = (k == 2'd2);
      end
      PH_DET: begin
        xrow = 2'd0;
        xcol = k;
        ysrc = YS_COF;
        op_sub = 1'b0;
        op_last = (k == 2'd3);
        op_cof = {k, 2'b00};
      end
      PH_DIV: begin
        op_cof = {r, c};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    phase_next = phase;
    r_next = r;
    c_next = c;
    m_next = m;
    k_next = k;
    rc_next = rc;
    cmd.cof_addr = op_cof;
    cmd.ysrc = ysrc;
    cmd.ycol = ycol;
    cmd.ymin = k;
    cmd.xcol = xcol;
    cmd.acc_clr = (k == 2'd0);
    cmd.acc_sub = op_sub;
    cmd.st_idx = m;
    cmd.div_col = c;
    cmd.wr_row = rc;
    cmd.mat_row = yrow;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.wr_en = 1'b1;
          rc_next = rc + 2'd1;
          if (rc == 2'd3) begin
            state_next = S_RDY;
            phase_next = PH_MINOR;
            r_next = '0;
            c_next = '0;
            m_next = '0;
            k_next = '0;
          end
        end
      end
      S_RDY: begin
        state_next = S_LDY;
      end
      S_LDY: begin
        cmd.ld_y = 1'b1;
        cmd.mat_row = xrow;
        state_next = S_LDX;
      end
      S_LDX: begin
        cmd.ld_x = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        if (status.mul_done) begin
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
        if (op_last) begin
          state_next = S_STORE;
        end else begin
          k_next = k + 2'd1;
          state_next = S_RDY;
        end
      end
      S_STORE: begin
        k_next = '0;
        state_next = S_RDY;
        case (phase)
          PH_MINOR: begin
            cmd.st_minor = 1'b1;
            if (m == 2'd2) begin
              m_next = '0;
              phase_next = PH_SUM;
            end else begin
              m_next = m + 2'd1;
            end
          end
          PH_SUM: begin
            cmd.st_cof = 1'b1;
            phase_next = PH_MINOR;
            c_next = c + 2'd1;
            if (c == 2'd3) begin
              r_next = r + 2'd1;
              if (r == 2'd3) begin
                phase_next = PH_DET;
              end
            end
          end
          default: begin
            cmd.st_det = 1'b1;
            phase_next = PH_DIV;
            r_next = '0;
            c_next = '0;
            state_next = S_DMAG;
          end
        endcase
      end
      S_DMAG: begin
        cmd.dmag_en = 1'b1;
        state_next = S_DRD;
      end
      S_DRD: begin
        state_next = S_DLD;
      end
      S_DLD: begin
        cmd.div_load = 1'b1;
        state_next = S_DPRE;
      end
      S_DPRE: begin
        cmd.div_pre = 1'b1;
        state_next = S_DCHK;
      end
      S_DCHK: begin
        cmd.div_chk = 1'b1;
        state_next = S_DIT;
      end
      S_DIT: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_DFIN;
        end
      end
      S_DFIN: begin
        cmd.div_fin = 1'b1;
        if (c == 2'd3) begin
          state_next = S_EMIT;
        end else begin
          c_next = c + 2'd1;
          state_next = S_DRD;
        end
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        c_next = '0;
        r_next = r + 2'd1;
        state_next = (r == 2'd3) ? S_IDLE : S_DRD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_MINOR;
      r <= '0;
      c <= '0;
      m <= '0;
      k <= '0;
      rc <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      r <= r_next;
      c <= c_next;
      m <= m_next;
      k <= k_next;
      rc <= rc_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign valid = (state == S_EMIT);
  assign last_row = (state == S_EMIT) && (r == 2'd3);

endmodule

FILE: rtl/core/minv_dp.sv
// Datapath: matrix and cofactor stores, shared multiplier, accumulator and divider.
`timescale 1ns / 1ps
module minv_dp import minv_pkg::*; #(
  parameter int ELEMENT_WIDTH = MINV_ELEMENT_WIDTH,
  parameter int FRAC_BITS = MINV_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  minv_cmd_t                       cmd,
  input  logic signed [ELEMENT_WIDTH-1:0] col0,
  input  logic signed [ELEMENT_WIDTH-1:0] col1,
  input  logic signed [ELEMENT_WIDTH-1:0] col2,
  input  logic signed [ELEMENT_WIDTH-1:0] col3,
  output minv_status_t                    status,
  output logic signed [ELEMENT_WIDTH-1:0] out0,
  output logic signed [ELEMENT_WIDTH-1:0] out1,
  output logic signed [ELEMENT_WIDTH-1:0] out2,
  output logic signed [ELEMENT_WIDTH-1:0] out3,
  output logic                            singular,
  output logic                            saturated
);

  localparam int W = ELEMENT_WIDTH;
  localparam int F = FRAC_BITS;
  localparam int MW = 2 * W + 1;
  localparam int CW = 3 * W + 3;
  localparam int DW = 4 * W + 5;
  localparam int CH = MINV_CHUNK;
  localparam int NCH = (CW + CH - 1) / CH;
  localparam int YW = NCH * CH;
  localparam int PW = W + CH + 1;
  localparam int RW = (CW + 2 * F + 2 > DW + W + 2) ? CW + 2 * F + 2 : DW + W + 2;
  localparam int MCW = $clog2(NCH + 1);
  localparam int DCW = $clog2(W + 1);
  localparam logic [W:0] HALF = (W + 1)'(1) << (W - 1);

  logic [4*W-1:0] mat_rd;
  logic [CW-1:0]  cof_rd;
  logic signed [CW-1:0] cof_s;
  logic signed [W-1:0]  ex, ey;

  minv_ram #(.WIDTH(4 * W), .DEPTH(4)) u_mat (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (cmd.wr_row),
    .wdata ({col3, col2, col1, col0}),
    .raddr (cmd.mat_row),
    .rdata (mat_rd)
  );

  logic signed [DW-1:0] acc;

  minv_ram #(.WIDTH(CW), .DEPTH(16)) u_cof (
    .clk   (clk),
    .we    (cmd.st_cof),
    .waddr (cmd.cof_addr),
    .wdata (acc[CW-1:0]),
    .raddr (cmd.cof_addr),
    .rdata (cof_rd)
  );

  assign cof_s = cof_rd;
  assign ex = mat_rd[cmd.xcol*W +: W];
  assign ey = mat_rd[cmd.ycol*W +: W];

  // Multiplier: element times wide operand, one slice of the wide operand per cycle,
  // most significant slice first.
  logic signed [W-1:0]  x;
  logic [YW-1:0]        y;
  logic signed [MW-1:0] tmin [3];
  logic signed [PW-1:0] prod;
  logic signed [CH:0]   chunk;
  logic signed [DW-1:0] p, det, acc_base, acc_add;
  logic [MCW-1:0]       mcnt;
  logic                 mrun, mdone;

  assign chunk = (mcnt == '0) ? {y[YW-1], y[YW-1 -: CH]} : {1'b0, y[YW-1 -: CH]};

  always_ff @(posedge clk) begin
    if (rst) begin
      mrun <= 1'b0;
      mdone <= 1'b0;
    end else if (cmd.ld_x) begin
      mrun <= 1'b1;
      mdone <= 1'b0;
    end else if (mrun && mcnt == MCW'(NCH)) begin
      mrun <= 1'b0;
      mdone <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_y) begin
      case (cmd.ysrc)
        YS_ELEM:  y <= YW'(ey);
        YS_MINOR: y <= YW'(tmin[cmd.ymin]);
        YS_COF:   y <= YW'(cof_s);
        default:  y <= '0;
      endcase
    end else if (mrun) begin
      y <= y << CH;
    end
    if (cmd.ld_x) begin
      x <= ex;
      mcnt <= '0;
      p <= '0;
    end else if (mrun) begin
      mcnt <= mcnt + MCW'(1);
      if (mcnt < MCW'(NCH)) begin
        prod <= x * chunk;
      end
      if (mcnt != '0) begin
        p <= (p << CH) + DW'(prod);
      end
    end
  end

  assign acc_base = cmd.acc_clr ? '0 : acc;
  assign acc_add = cmd.acc_sub ? -p : p;

  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      acc <= acc_base + acc_add;
    end
    if (cmd.st_minor) begin
      tmin[cmd.st_idx] <= acc[MW-1:0];
    end
    if (cmd.st_det) begin
      det <= acc;
    end
  end

  // Divider: rounded quotient of the scaled cofactor by the determinant, one bit per cycle.
  logic [DW-1:0]  dmag;
  logic [CW-1:0]  cmag;
  logic [RW-1:0]  rem, dcur;
  logic [W:0]     q, mag, val;
  logic [DCW-1:0] dcnt;
  logic           negq, ovf, sing, sat_raw, row_sat;
  logic [W-1:0]   orow [4];

  always_ff @(posedge clk) begin
    if (cmd.dmag_en) begin
      dmag <= det[DW-1] ? DW'(-det) : DW'(det);
      sing <= (det == '0);
    end
    if (cmd.div_load) begin
      negq <= cof_s[CW-1] ^ det[DW-1];
      cmag <= cof_s[CW-1] ? CW'(-cof_s) : CW'(cof_s);
    end
    if (cmd.div_pre) begin
      rem <= (RW'(cmag) << (2 * F + 1)) + RW'(dmag);
      dcur <= RW'({dmag, 1'b0}) << W;
      dcnt <= DCW'(W);
    end
    if (cmd.div_chk) begin
      ovf <= (rem >= (dcur << 1));
      q <= '0;
    end
    if (cmd.div_step) begin
      if (rem >= dcur) begin
        rem <= rem - dcur;
        q <= {q[W-1:0], 1'b1};
      end else begin
        q <= {q[W-1:0], 1'b0};
      end
      dcur <= dcur >> 1;
      dcnt <= dcnt - DCW'(1);
    end
    if (cmd.div_fin) begin
      orow[cmd.div_col] <= sing ? '0 : val[W-1:0];
    end
  end

  always_comb begin
    sat_raw = ovf | (negq ? (q > HALF) : (q > HALF - (W + 1)'(1)));
    mag = sat_raw ? (negq ? HALF : HALF - (W + 1)'(1)) : q;
    val = negq ? (~mag + (W + 1)'(1)) : mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_sat <= 1'b0;
    end else if (cmd.emit) begin
      row_sat <= 1'b0;
    end else if (cmd.div_fin) begin
      row_sat <= row_sat | (sat_raw & ~sing);
    end
  end

  assign status.mul_done = mdone;
  assign status.div_last = (dcnt == '0);
  assign out0 = orow[0];
  assign out1 = orow[1];
  assign out2 = orow[2];
  assign out3 = orow[3];
  assign singular = sing;
  assign saturated = row_sat;

endmodule

FILE: rtl/core/matrix_inverse_4x4.sv
// Top level of the 4x4 fixed-point matrix inverse.
`timescale 1ns / 1ps
// A matrix enters one row per transaction, col0..col3 being the signed fixed-point
// elements of that row (Q16.16 at the default widths); a transaction is taken at a
// rising edge where start is high and busy is low. The first three rows are stored and
// busy stays low. The fourth row is stored too and starts the computation: busy goes
// high, the sixteen cofactors are formed exactly on one shared multiplier that eats the
// wide operand sixteen bits per cycle, the determinant follows by expansion along the
// first row, and each inverse element is produced by a restoring divider that yields
// one quotient bit per cycle, rounded to nearest with ties away from zero. Four result
// rows then appear, each valid for exactly one cycle, with last_row on the fourth; the
// receiver cannot hold them off and must take each one when valid is high. At the
// default widths the fourth row sets off 148 multiply steps, each over the NCH 16-bit
// slices of the wide operand (NCH is the number of 16-bit slices of a cofactor, seven
// here), plus sixteen divisions. When the determinant is zero every row carries zeros
// with singular set. Elements that do not fit the output format are clipped to the
// largest magnitude and flag saturated on that row.
module matrix_inverse_4x4 import minv_pkg::*; #(
  parameter int ELEMENT_WIDTH = MINV_ELEMENT_WIDTH,
  parameter int FRAC_BITS = MINV_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [ELEMENT_WIDTH-1:0] col0,
  input  logic signed [ELEMENT_WIDTH-1:0] col1,
  input  logic signed [ELEMENT_WIDTH-1:0] col2,
  input  logic signed [ELEMENT_WIDTH-1:0] col3,
  output logic                            valid,
  output logic signed [ELEMENT_WIDTH-1:0] out0,
  output logic signed [ELEMENT_WIDTH-1:0] out1,
  output logic signed [ELEMENT_WIDTH-1:0] out2,
  output logic signed [ELEMENT_WIDTH-1:0] out3,
  output logic                            singular,
  output logic                            saturated,
  output logic                            last_row
);

  // Commands flow from the sequencer to the datapath; status flows back.
  minv_cmd_t    cmd;
  minv_status_t status;

  minv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy),
    .valid    (valid),
    .last_row (last_row)
  );

  minv_dp #(
    .ELEMENT_WIDTH (ELEMENT_WIDTH),
    .FRAC_BITS     (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .col0      (col0),
    .col1      (col1),
    .col2      (col2),
    .col3      (col3),
    .status    (status),
    .out0      (out0),
    .out1      (out1),
    .out2      (out2),
    .out3      (out3),
    .singular  (singular),
    .saturated (saturated)
  );

endmodule

FILE: rtl/core/minv_checker.sv
// Port-level checker for the matrix inverse, bound to the top level.
`timescale 1ns / 1ps
module minv_checker import minv_pkg::*; #(
  parameter int ELEMENT_WIDTH = MINV_ELEMENT_WIDTH
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic                     valid,
  input logic [ELEMENT_WIDTH-1:0] out0,
  input logic [ELEMENT_WIDTH-1:0] out1,
  input logic [ELEMENT_WIDTH-1:0] out2,
  input logic [ELEMENT_WIDTH-1:0] out3,
  input logic                     singular,
  input logic                     saturated,
  input logic                     last_row
);

  // Results only come out while a matrix is being worked on.
  a_valid_busy: assert property (@(posedge clk) disable iff (rst) valid |-> busy)
    else $error("result transaction while idle");

  // The last row ends the computation.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    valid && last_row |=> !busy)
    else $error("still busy after last row");

  // Result rows are separated by divider work, never back to back.
  a_row_gap: assert property (@(posedge clk) disable iff (rst)
    valid && !last_row |=> !valid)
    else $error("result rows back to back");

  // A singular matrix gives zero rows without clipping.
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    valid && singular |-> out0 == '0 && out1 == '0 && out2 == '0 && out3 == '0 && !saturated)
    else $error("singular row not zero");

  // Work only starts from an accepted row.
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy without a transaction");

endmodule

bind matrix_inverse_4x4 minv_checker #(.ELEMENT_WIDTH(ELEMENT_WIDTH)) u_minv_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .valid     (valid),
  .out0      (out0),
  .out1      (out1),
  .out2      (out2),
  .out3      (out3),
  .singular  (singular),
  .saturated (saturated),
  .last_row  (last_row)
);

FILE: bench/testbench.sv
// Self-checking testbench for the 4x4 fixed-point matrix inverse.
`timescale 1ns / 1ps
module testbench;
  import minv_pkg::*;

  localparam int EW = MINV_ELEMENT_WIDTH;
  localparam int FB = MINV_FRAC_BITS;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;

  typedef logic signed [255:0] wide_t;
  typedef logic signed [EW-1:0] elem_t;

  typedef struct {
    elem_t e[4];
  } row_t;

  typedef struct {
    elem_t v[4];
    logic  sing;
    logic  sat;
    logic  last;
  } inv_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  elem_t col0 = '0, col1 = '0, col2 = '0, col3 = '0;
  logic valid;
  elem_t out0, out1, out2, out3;
  logic singular, saturated, last_row;

  matrix_inverse_4x4 dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .col0(col0), .col1(col1), .col2(col2), .col3(col3),
    .valid(valid), .out0(out0), .out1(out1), .out2(out2), .out3(out3),
    .singular(singular), .saturated(saturated), .last_row(last_row)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Rows waiting to be driven, and inverse rows waiting to come back.
  row_t     pending_rows[$];
  inv_row_t expected_rows[$];

  // The predictor's own copy of the block's state.
  elem_t    shadow_store[16];
  int       shadow_row = 0;

  int errors = 0;
  int rows_sent = 0;
  int rows_seen = 0;
  int singular_seen = 0;
  int saturated_seen = 0;
  int idle_cycles = 0;
  int gap = 0;
  logic took = 1'b0;

  function automatic wide_t cofactor_of(int sr, int sc);
    wide_t a[3][3];
    wide_t t0, t1, t2, d;
    int rows[3], cols[3];
    int n, m;
    n = 0;
    m = 0;
    for (int k = 0; k < 4; k++) begin
      if (k != sr) begin
        rows[n] = k;
        n++;
      end
      if (k != sc) begin
        cols[m] = k;
        m++;
      end
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        a[i][j] = shadow_store[rows[i] * 4 + cols[j]];
    t0 = a[1][1] * a[2][2] - a[1][2] * a[2][1];
    t1 = a[1][0] * a[2][2] - a[1][2] * a[2][0];
    t2 = a[1][0] * a[2][1] - a[1][1] * a[2][0];
    d = a[0][0] * t0 - a[0][1] * t1 + a[0][2] * t2;
    return ((sr + sc) % 2 == 1) ? -d : d;
  endfunction

  // Stores one row; after the fourth it queues the four rows of the inverse.
  task automatic predict_inverse(row_t r);
    wide_t cof[4][4];
    wide_t det, dmag, num, q, wide_elem;
    logic  negq;
    inv_row_t o;
    for (int k = 0; k < 4; k++) shadow_store[shadow_row * 4 + k] = r.e[k];
    if (shadow_row != 3) begin
      shadow_row++;
      return;
    end
    shadow_row = 0;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) cof[i][j] = cofactor_of(i, j);
    det = '0;
    for (int j = 0; j < 4; j++) begin
      wide_elem = shadow_store[j];
      det = det + wide_elem * cof[0][j];
    end
    dmag = (det < 0) ? -det : det;
    for (int i = 0; i < 4; i++) begin
      o.sing = (det == 0);
      o.sat = 1'b0;
      o.last = (i == 3);
      for (int j = 0; j < 4; j++) begin
        if (o.sing) begin
          o.v[j] = '0;
        end else begin
          num = cof[j][i];
          negq = (num < 0) != (det < 0);
          num = (num < 0) ? -num : num;
          num = num <<< (2 * FB);
          // Round to nearest, ties away from zero, on magnitudes.
          q = $signed($unsigned((num <<< 1) + dmag) / $unsigned(dmag <<< 1));
          if (negq && q > (wide_t'(1) <<< (EW - 1))) begin
            q = wide_t'(1) <<< (EW - 1);
            o.sat = 1'b1;
          end else if (!negq && q > ((wide_t'(1) <<< (EW - 1)) - 1)) begin
            q = (wide_t'(1) <<< (EW - 1)) - 1;
            o.sat = 1'b1;
          end
          o.v[j] = negq ? -q[EW-1:0] : q[EW-1:0];
        end
      end
      expected_rows.push_back(o);
    end
  endtask

  // Driver: inputs change on the falling edge; a held start stays up until taken.
  always @(negedge clk) begin
    row_t r;
    if (rst) begin
      start <= 1'b0;
    end else if (start && !took) begin
      start <= 1'b1;
    end else if (gap > 0) begin
      start <= 1'b0;
      gap <= gap - 1;
    end else if (pending_rows.size() > 0) begin
      r = pending_rows.pop_front();
      col0 <= r.e[0];
      col1 <= r.e[1];
      col2 <= r.e[2];
      col3 <= r.e[3];
      start <= 1'b1;
      gap <= $urandom_range(0, 3);
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: samples on the rising edge, predicts and checks each transaction.
  always @(posedge clk) begin
    row_t r;
    inv_row_t x;
    elem_t got[4];
    if (rst) begin
      took <= 1'b0;
    end else begin
      took <= start && !busy;
      if (start && !busy) begin
        r.e[0] = col0;
        r.e[1] = col1;
        r.e[2] = col2;
        r.e[3] = col3;
        predict_inverse(r);
        rows_sent++;
      end
      if (valid) begin
        rows_seen++;
        if (singular) singular_seen++;
        if (saturated) saturated_seen++;
        if (expected_rows.size() == 0) begin
          $error("result row with no expectation waiting");
          errors++;
        end else begin
          x = expected_rows.pop_front();
          got[0] = out0;
          got[1] = out1;
          got[2] = out2;
          got[3] = out3;
          for (int j = 0; j < 4; j++)
            if (got[j] !== x.v[j]) begin
              $error("out%0d: expected %h, got %h", j, x.v[j], got[j]);
              errors++;
            end
          if (singular !== x.sing) begin
            $error("singular: expected %b, got %b", x.sing, singular);
            errors++;
          end
          if (saturated !== x.sat) begin
            $error("saturated: expected %b, got %b", x.sat, saturated);
            errors++;
          end
          if (last_row !== x.last) begin
            $error("last_row: expected %b, got %b", x.last, last_row);
            errors++;
          end
        end
      end
      // Watchdog on cycles with no transaction in either direction.
      if ((start && !busy) || valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  task automatic push_row(elem_t a, elem_t b, elem_t c, elem_t d);
    row_t r;
    r.e[0] = a;
    r.e[1] = b;
    r.e[2] = c;
    r.e[3] = d;
    pending_rows.push_back(r);
  endtask

  function automatic elem_t rand_elem(int kind);
    case (kind)
      0: return elem_t'($urandom());
      1: return elem_t'($urandom_range(0, 1 << 19)) - elem_t'(1 << 18);
      default: begin
        case ($urandom_range(0, 4))
          0: return elem_t'(32'h8000_0000);
          1: return elem_t'(32'h7fff_ffff);
          2: return '0;
          default: return elem_t'($urandom());
        endcase
      end
    endcase
  endfunction

  initial begin
    elem_t one, m[4][4];
    int kind, a, b;
    one = elem_t'(1 << FB);

    // Identity: inverse equals the input.
    push_row(one, 0, 0, 0);
    push_row(0, one, 0, 0);
    push_row(0, 0, one, 0);
    push_row(0, 0, 0, one);
    // Tiny diagonal: the inverse overflows and clips positive and negative.
    push_row(elem_t'(1), 0, 0, 0);
    push_row(0, -elem_t'(1), 0, 0);
    push_row(0, 0, elem_t'(2), 0);
    push_row(0, 0, 0, one);
    // All zeros: singular matrix.
    for (int i = 0; i < 4; i++) push_row(0, 0, 0, 0);
    // Extremes of the element range on a permuted diagonal.
    push_row(0, elem_t'(32'h7fff_ffff), 0, 0);
    push_row(elem_t'(32'h8000_0000), 0, 0, 0);
    push_row(0, 0, 0, elem_t'(32'h8000_0000));
    push_row(0, 0, elem_t'(32'h7fff_ffff), 0);
    // All ones in every bit pattern sense: all -1 LSB elements, singular.
    for (int i = 0; i < 4; i++) push_row(-elem_t'(1), -elem_t'(1), -elem_t'(1), -elem_t'(1));
    // Mixed-sign well-conditioned matrix.
    push_row(2 * one, -one, 0, one / 2);
    push_row(-one, 2 * one, -one, 0);
    push_row(0, -one, 2 * one, -one);
    push_row(one / 4, 0, -one, 2 * one);

    // Random matrices: mostly moderate values, some full range, some singular.
    for (int n = 0; n < 34; n++) begin
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 4; i++)
        for (int j = 0; j < 4; j++)
          m[i][j] = rand_elem(kind < 2 ? 0 : (kind < 8 ? 1 : 2));
      if (kind == 7 || kind == 6) begin
        // Duplicate or negated row forces a zero determinant.
        a = $urandom_range(0, 3);
        b = (a + $urandom_range(1, 3)) % 4;
        for (int j = 0; j < 4; j++) m[b][j] = (kind == 6) ? -m[a][j] : m[a][j];
      end
      for (int i = 0; i < 4; i++) push_row(m[i][0], m[i][1], m[i][2], m[i][3]);
    end

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    wait (pending_rows.size() == 0);
    @(posedge clk);
    wait (!start);
    wait (expected_rows.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d input rows sent, %0d inverse rows checked", rows_sent, rows_seen);
    $display("%0d rows flagged singular, %0d rows flagged saturated",
             singular_seen, saturated_seen);
    if (errors == 0 && expected_rows.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
